/* rtl/iaf_pkg.sv */
// iaf_pkg: shared types, codes and constants for the integer to ascii formatter
// no dependencies; used by iaf_ctrl, iaf_dpath and integer_to_ascii_formatter_top
package iaf_pkg;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] value;
      logic [3:0]  zero_fill;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

   // request kinds
   localparam logic [2:0] ACT_LITERAL   = 3'd0;
   localparam logic [2:0] ACT_SIGNED16  = 3'd1;
   localparam logic [2:0] ACT_UNSIGNED16 = 3'd2;
   localparam logic [2:0] ACT_SIGNED32  = 3'd3;
   localparam logic [2:0] ACT_UNSIGNED32 = 3'd4;
   localparam logic [2:0] ACT_HEX16     = 3'd5;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   // power-of-ten table index: 0 is 10^9, 9 is 10^0
   localparam logic [3:0] POW_IDX_FIRST32 = 4'd0;
   localparam logic [3:0] POW_IDX_FIRST16 = 4'd5;
   localparam logic [3:0] POW_IDX_LAST    = 4'd9;
   localparam logic [1:0] NIB_TOP         = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SKIP,
      ST_SUB,
      ST_DIG,
      ST_HEX
   } state_type;

   typedef enum logic [2:0] {
      EMIT_LIT,
      EMIT_MINUS,
      EMIT_ZERO,
      EMIT_DIG,
      EMIT_HEX
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      emit_sel_type emit_sel;
      logic         last;
      logic         k_inc;
      logic         sub;
      logic         dig_clr;
      logic         nib_dec;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       neg;
      logic       is_zero;
      logic       ge;
      logic       k_last;
      logic       k_lt_last;
      logic       hex_show;
      logic       nib_last;
      logic       out_free;
   } status_type;

   function automatic logic [31:0] pow10(input logic [3:0] idx);
      logic [31:0] p;
      case (idx)
         4'd0:    p = 32'd1000000000;
         4'd1:    p = 32'd100000000;
         4'd2:    p = 32'd10000000;
         4'd3:    p = 32'd1000000;
         4'd4:    p = 32'd100000;
         4'd5:    p = 32'd10000;
         4'd6:    p = 32'd1000;
         4'd7:    p = 32'd100;
         4'd8:    p = 32'd10;
         default: p = 32'd1;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'b0000, nib};
      end else begin
         c = CHAR_UPPER_A + {4'b0000, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

/* rtl/iaf_dpath.sv */
// iaf_dpath: operand, digit and nibble registers, subtract unit and output register
// depends on iaf_pkg; driven by iaf_ctrl through cmd_type / status_type
module iaf_dpath (
   input  logic               clock,
   input  logic               reset,
   input  iaf_pkg::req_type   req_item,
   input  iaf_pkg::cmd_type   cmd,
   output iaf_pkg::status_type st,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output iaf_pkg::rsp_type   rsp_item
);

   logic [2:0]  act_ff,  act_in;
   logic [3:0]  fill_ff, fill_in;
   logic        neg_ff,  neg_in;
   logic [31:0] x_ff,    x_in;
   logic [3:0]  k_ff,    k_in;
   logic [3:0]  dig_ff,  dig_in;
   logic [1:0]  nib_ff,  nib_in;
   logic        rsp_valid_ff, rsp_valid_in;
   iaf_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic [31:0] pow_w;
   logic        ge_w;
   logic [15:0] sh_w;
   logic        out_free_w;
   logic [7:0]  char_w;
   logic [15:0] v16_w;

   assign pow_w      = iaf_pkg::pow10(k_ff);
   assign ge_w       = (x_ff >= pow_w);
   assign sh_w       = x_ff[15:0] >> {nib_ff, 2'b00};
   assign out_free_w = !rsp_valid_ff || !rsp_stall;
   assign v16_w      = req_item.value[15:0];

   always_comb begin
      st.action    = act_ff;
      st.neg       = neg_ff;
      st.is_zero   = (x_ff == 32'd0);
      st.ge        = ge_w;
      st.k_last    = (k_ff == iaf_pkg::POW_IDX_LAST);
      st.k_lt_last = (k_ff < iaf_pkg::POW_IDX_LAST);
      st.nib_last  = (nib_ff == 2'd0);
      st.hex_show  = (nib_ff == 2'd0) || (sh_w != 16'd0) ||
                     (fill_ff >= ({2'b00, nib_ff} + 4'd1));
      st.out_free  = out_free_w;
   end

   always_comb begin
      case (cmd.emit_sel)
         iaf_pkg::EMIT_LIT:   char_w = x_ff[7:0];
         iaf_pkg::EMIT_MINUS: char_w = iaf_pkg::CHAR_MINUS;
         iaf_pkg::EMIT_ZERO:  char_w = iaf_pkg::CHAR_ZERO;
         iaf_pkg::EMIT_DIG:   char_w = iaf_pkg::CHAR_ZERO + {4'b0000, dig_ff};
         iaf_pkg::EMIT_HEX:   char_w = iaf_pkg::hex_char(sh_w[3:0]);
         default:             char_w = iaf_pkg::CHAR_ZERO;
      endcase
   end

   always_comb begin
      act_in  = act_ff;
      fill_in = fill_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      k_in    = k_ff;
      dig_in  = dig_ff;
      nib_in  = nib_ff;
      if (cmd.load) begin
         act_in  = req_item.action;
         fill_in = req_item.zero_fill;
         neg_in  = 1'b0;
         dig_in  = 4'd0;
         nib_in  = iaf_pkg::NIB_TOP;
         k_in    = iaf_pkg::POW_IDX_FIRST32;
         x_in    = req_item.value;
         case (req_item.action)
            iaf_pkg::ACT_SIGNED16: begin
               k_in   = iaf_pkg::POW_IDX_FIRST16;
               neg_in = v16_w[15];
               x_in   = v16_w[15] ? {16'd0, 16'(16'd0 - v16_w)} : {16'd0, v16_w};
            end
            iaf_pkg::ACT_UNSIGNED16, iaf_pkg::ACT_HEX16: begin
               k_in = iaf_pkg::POW_IDX_FIRST16;
               x_in = {16'd0, v16_w};
            end
            iaf_pkg::ACT_SIGNED32: begin
               neg_in = req_item.value[31];
               x_in   = req_item.value[31] ? 32'd0 - req_item.value : req_item.value;
            end
            default: begin
            end
         endcase
      end else begin
         if (cmd.sub) begin
            x_in   = x_ff - pow_w;
            dig_in = dig_ff + 4'd1;
         end
         if (cmd.dig_clr) begin
            dig_in = 4'd0;
         end
         if (cmd.k_inc) begin
            k_in = k_ff + 4'd1;
         end
         if (cmd.nib_dec) begin
            nib_in = nib_ff - 2'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (cmd.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_item_in.out_char = char_w;
         rsp_item_in.last     = cmd.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      fill_ff     <= fill_in;
      neg_ff      <= neg_in;
      x_ff        <= x_in;
      k_ff        <= k_in;
      dig_ff      <= dig_in;
      nib_ff      <= nib_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free_w)
      else $error("emit while output register is held");

   a_sub_ge: assert property (@(posedge clock) disable iff (reset)
      cmd.sub |-> ge_w)
      else $error("subtract would underflow");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_sel == iaf_pkg::EMIT_DIG) |-> dig_ff <= 4'd9)
      else $error("decimal digit out of range");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      cmd.k_inc |-> k_ff < iaf_pkg::POW_IDX_LAST)
      else $error("power index past last entry");

endmodule

/* rtl/iaf_ctrl.sv */
// iaf_ctrl: sequencer that walks one request through sign, digit search and emission
// depends on iaf_pkg; commands iaf_dpath through cmd_type / status_type
module iaf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  iaf_pkg::status_type st,
   output iaf_pkg::cmd_type    cmd
);

   iaf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iaf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.emit_sel = iaf_pkg::EMIT_LIT;
      req_stall    = 1'b1;
      case (state_ff)
         iaf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = iaf_pkg::ST_START;
            end
         end
         iaf_pkg::ST_START: begin
            case (st.action)
               iaf_pkg::ACT_LITERAL: begin
                  if (st.out_free) begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     state_in = iaf_pkg::ST_IDLE;
                  end
               end
               iaf_pkg::ACT_SIGNED16, iaf_pkg::ACT_SIGNED32: begin
                  if (!st.neg) begin
                     state_in = iaf_pkg::ST_SKIP;
                  end else if (st.out_free) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = iaf_pkg::EMIT_MINUS;
                     state_in     = iaf_pkg::ST_SKIP;
                  end
               end
               iaf_pkg::ACT_UNSIGNED16, iaf_pkg::ACT_UNSIGNED32: begin
                  state_in = iaf_pkg::ST_SKIP;
               end
               iaf_pkg::ACT_HEX16: begin
                  state_in = iaf_pkg::ST_HEX;
               end
               default: begin
                  // unused kinds produce nothing
                  state_in = iaf_pkg::ST_IDLE;
               end
            endcase
         end
         iaf_pkg::ST_SKIP: begin
            // drop leading powers larger than the operand
            if (st.is_zero) begin
               if (st.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = iaf_pkg::EMIT_ZERO;
                  cmd.last     = 1'b1;
                  state_in     = iaf_pkg::ST_IDLE;
               end
            end else if (st.k_lt_last && !st.ge) begin
               cmd.k_inc = 1'b1;
            end else begin
               state_in = iaf_pkg::ST_SUB;
            end
         end
         iaf_pkg::ST_SUB: begin
            if (st.ge) begin
               cmd.sub = 1'b1;
            end else begin
               state_in = iaf_pkg::ST_DIG;
            end
         end
         iaf_pkg::ST_DIG: begin
            if (st.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = iaf_pkg::EMIT_DIG;
               cmd.last     = st.k_last;
               cmd.dig_clr  = 1'b1;
               if (st.k_last) begin
                  state_in = iaf_pkg::ST_IDLE;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = iaf_pkg::ST_SUB;
               end
            end
         end
         iaf_pkg::ST_HEX: begin
            if (!st.hex_show) begin
               cmd.nib_dec = 1'b1;
            end else if (st.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = iaf_pkg::EMIT_HEX;
               cmd.last     = st.nib_last;
               if (st.nib_last) begin
                  state_in = iaf_pkg::ST_IDLE;
               end else begin
                  cmd.nib_dec = 1'b1;
               end
            end
         end
         default: begin
            state_in = iaf_pkg::ST_IDLE;
         end
      endcase
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == iaf_pkg::ST_START)
      else $error("load did not start a request");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is in flight");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> state_ff == iaf_pkg::ST_IDLE)
      else $error("last character did not end the request");

endmodule

/* rtl/integer_to_ascii_formatter_top.sv */
// integer_to_ascii_formatter_top: top level joining sequencer and datapath
// depends on iaf_pkg, iaf_ctrl and iaf_dpath
//
// usage:
//   req channel (req_valid / req_stall / req_item) takes one conversion request:
//   a literal character, a signed or unsigned 16 or 32 bit decimal value, or a
//   16 bit hex value with a minimum digit count
//   rsp channel (rsp_valid / rsp_stall / rsp_item) returns the characters one
//   item each, with last set on the final character; kinds 6 and 7 return none
// timing:
//   one request at a time; req_stall is high from the cycle after acceptance
//   until the request's last character has been loaded into the output register
//   decimal digits come from repeated subtraction of powers of ten, one
//   subtract per cycle: each digit is counted in the subtract state until the
//   operand drops below the power, then emitted from the digit state; leading
//   powers are skipped at one per cycle; a literal or minus sign is loaded from
//   the start state, once the output register is free
// reset: synchronous, returns the sequencer to idle and empties the output register
// stall: a stalled character holds in the output register and the sequencer
//   waits before it loads the next one
module integer_to_ascii_formatter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iaf_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iaf_pkg::rsp_type rsp_item
);

   iaf_pkg::cmd_type    cmd;
   iaf_pkg::status_type st;

   iaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   iaf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .st        (st),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
